[rtl/core/sit_pkg.sv]
// Package for the sorted IP record table: kinds, status codes and controller states.
package sit_pkg;
  localparam int unsigned CAPACITY_DEF = 256;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic srch_step;  // advance binary search / linear scan
    logic rd_issue;   // issue memory read for shift
    logic shift_wr;   // write shifted entry
    logic ins_wr;     // write new record and bump count
    logic clr;        // empty table
  } sit_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic srch_done;
    logic shift_done;
    logic full;
  } sit_sts_t;
endpackage

[rtl/core/sorted_ip_record_table.sv]
// Sorted IP record table: top level joining controller and datapath.
// Keeps up to CAPACITY records (address, interface id, position) in ascending address
// order, equal addresses in arrival order, in one single-port-write memory. An insert
// binary-searches for its slot, then shifts each later record up one place. A lookup
// scans from the start until the first record matching address and interface. One
// request is handled at a time; the result is held in out_* until taken. No clearing
// pass follows reset: entries are read only below the fill count.
module sorted_ip_record_table #(
  parameter int unsigned CAPACITY = sit_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_ip_addr,
  input  logic [7:0]  in_iface_id,
  input  logic [31:0] in_file_pos,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_pos,
  output logic [8:0]  out_entry_count
);
  import sit_pkg::*;

  sit_cmd_t cmd;
  sit_sts_t sts;
  logic res_load;
  logic [1:0]  res_status;
  logic [31:0] res_found_pos;
  logic [8:0]  res_entry_count;

  sit_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_kind, .in_stall, .out_valid, .out_stall,
    .res_load, .cmd, .sts
  );

  sit_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_kind, .in_ip_addr, .in_iface_id, .in_file_pos,
    .res_status, .res_found_pos, .res_entry_count
  );

  // Result register; clear/unknown load on the accept cycle, so patch codes there
  always_ff @(posedge clk) begin
    if (res_load) begin
      if (cmd.load) begin
        out_status      <= ST_OK;
        out_found_pos   <= '0;
        out_entry_count <= cmd.clr ? 9'd0 : res_entry_count;
      end else begin
        out_status      <= res_status;
        out_found_pos   <= res_found_pos;
        out_entry_count <= cmd.ins_wr ? res_entry_count + 9'd1 : res_entry_count;
      end
    end
  end
endmodule

[rtl/core/sit_datapath.sv]
// Datapath of the sorted IP record table: record memory, search and shift registers.
module sit_datapath #(
  parameter int unsigned CAPACITY = sit_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sit_pkg::sit_cmd_t  cmd,
  output sit_pkg::sit_sts_t  sts,
  input  logic [1:0]         in_kind,
  input  logic [31:0]        in_ip_addr,
  input  logic [7:0]         in_iface_id,
  input  logic [31:0]        in_file_pos,
  output logic [1:0]         res_status,
  output logic [31:0]        res_found_pos,
  output logic [8:0]         res_entry_count
);
  import sit_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = AW + 1;

  logic [71:0] mem [CAPACITY];

  logic [1:0]  kind_r;
  logic [31:0] addr_r, pos_r;
  logic [7:0]  iface_r;
  logic [CW-1:0] count_r, lo_r, hi_r, idx_r;
  logic          hit_r;
  logic [31:0]   hitpos_r;
  logic [71:0]   rd_r;
  logic [CW-1:0] mid;
  logic [AW-1:0] rd_addr;
  logic [71:0]   wr_data;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic          scanning;

  assign scanning = (kind_r == KIND_LOOKUP);
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  // Read address: search probe or scan index, or entry below the shift hole
  always_comb begin
    if (cmd.rd_issue) rd_addr = AW'(idx_r - CW'(1));
    else if (scanning) rd_addr = idx_r[AW-1:0];
    else rd_addr = mid[AW-1:0];
  end

  always_comb begin
    wr_en   = cmd.shift_wr | cmd.ins_wr;
    wr_addr = cmd.shift_wr ? idx_r[AW-1:0] : lo_r[AW-1:0];
    wr_data = cmd.shift_wr ? rd_r : {addr_r, iface_r, pos_r};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  // Search: rd_r holds the entry read in the previous step. Steps alternate via a
  // phase bit: one step issues the read, the next consumes it.
  logic ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ph_r    <= 1'b0;
    end else begin
      if (cmd.load) begin
        kind_r  <= in_kind;
        addr_r  <= in_ip_addr;
        iface_r <= in_iface_id;
        pos_r   <= in_file_pos;
        lo_r    <= '0;
        hi_r    <= count_r;
        idx_r   <= '0;
        hit_r   <= 1'b0;
        hitpos_r <= '0;
        ph_r    <= 1'b0;
      end
      if (cmd.srch_step) begin
        ph_r <= ~ph_r;
        if (ph_r) begin
          if (scanning) begin
            if (rd_r[71:40] == addr_r && rd_r[39:32] == iface_r) begin
              hit_r    <= 1'b1;
              hitpos_r <= rd_r[31:0];
            end
            idx_r <= idx_r + CW'(1);
          end else if (rd_r[71:40] <= addr_r) begin
            lo_r <= mid + CW'(1);
          end else begin
            hi_r <= mid;
          end
        end
      end
      if (cmd.shift_wr) idx_r <= idx_r - CW'(1);
      if (cmd.ins_wr) count_r <= count_r + CW'(1);
      if (cmd.clr) count_r <= '0;
      if (!scanning && sts.srch_done && !cmd.shift_wr && !cmd.rd_issue && cmd.srch_step)
        idx_r <= count_r;
    end
  end

  always_comb begin
    sts.full       = (count_r >= CW'(CAPACITY));
    sts.srch_done  = scanning ? (hit_r || idx_r >= count_r) : (lo_r >= hi_r);
    sts.shift_done = (idx_r <= lo_r);
  end

  always_comb begin
    res_status = ST_OK;
    res_found_pos = '0;
    if (kind_r == KIND_INSERT && sts.full && !cmd.ins_wr) res_status = ST_FULL;
    if (kind_r == KIND_LOOKUP) begin
      res_status    = hit_r ? ST_OK : ST_NOT_FOUND;
      res_found_pos = hit_r ? hitpos_r : '0;
    end
    res_entry_count = 9'(count_r);
  end
endmodule

[rtl/core/sit_ctrl.sv]
// Controller state machine of the sorted IP record table.
module sit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              res_load,
  output sit_pkg::sit_cmd_t cmd,
  input  sit_pkg::sit_sts_t sts
);
  import sit_pkg::*;

  state_t state_r, state_nxt;
  logic [1:0] kind_r;
  logic acc;

  assign acc = in_valid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    if (acc) kind_r <= in_kind;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_kind inside {KIND_INSERT, KIND_LOOKUP}) state_nxt = S_SEARCH;
          else state_nxt = S_DONE;
        end
      end
      S_SEARCH: begin
        if (kind_r == KIND_INSERT && sts.full) state_nxt = S_DONE;
        else if (sts.srch_done) state_nxt = (kind_r == KIND_INSERT) ? S_READ : S_DONE;
      end
      S_READ:  state_nxt = sts.shift_done ? S_WRITE : S_SHIFT;
      S_SHIFT: state_nxt = S_READ;
      S_WRITE: state_nxt = S_DONE;
      S_DONE:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_stall = (state_r != S_IDLE);
    out_valid = 1'b0;
    res_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.load = acc;
        cmd.clr  = acc && in_kind == KIND_CLEAR;
      end
      S_SEARCH: begin
        if (!(kind_r == KIND_INSERT && sts.full)) cmd.srch_step = 1'b1;
        if (kind_r == KIND_INSERT && sts.full) res_load = 1'b1;
        else if (sts.srch_done && kind_r != KIND_INSERT) res_load = 1'b1;
      end
      S_READ:  cmd.rd_issue = !sts.shift_done;
      S_SHIFT: cmd.shift_wr = 1'b1;
      S_WRITE: begin
        cmd.ins_wr = 1'b1;
        res_load   = 1'b1;
      end
      S_DONE:  out_valid = 1'b1;
      default: ;
    endcase
    if (state_r == S_IDLE && acc && !(in_kind inside {KIND_INSERT, KIND_LOOKUP}))
      res_load = 1'b1;
  end

  ap_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("input taken while busy");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  ap_one_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.shift_wr && cmd.ins_wr)) else $error("double write");
endmodule

[test/sit_result_checker.sv]
// Checker for the sorted IP record table: predicts each result and compares it.
`timescale 1ns / 1ps
module sit_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_ip_addr,
  input  logic [7:0]  in_iface_id,
  input  logic [31:0] in_file_pos,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_found_pos,
  input  logic [8:0]  out_entry_count,
  output int          fail_count,
  output int          pending_count
);
  import sit_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_pos;
    logic [8:0]  entry_count;
  } table_reply_t;

  localparam int unsigned DEPTH = CAPACITY_DEF;

  logic [31:0]  key_mirror   [DEPTH];
  logic [7:0]   iface_mirror [DEPTH];
  logic [31:0]  pos_mirror   [DEPTH];
  int unsigned  held;
  table_reply_t reply_queue [$];

  // Models one request against the mirror table and returns its reply.
  function automatic table_reply_t apply_request(logic [1:0] kind, logic [31:0] addr,
                                                 logic [7:0] iface, logic [31:0] fpos);
    table_reply_t r;
    int unsigned  slot;
    r = '{status: ST_OK, found_pos: '0, entry_count: '0};
    if (kind == KIND_INSERT) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot = 0;
        while (slot < held && key_mirror[slot] <= addr) slot++;
        for (int j = held; j > slot; j--) begin
          key_mirror[j]   = key_mirror[j-1];
          iface_mirror[j] = iface_mirror[j-1];
          pos_mirror[j]   = pos_mirror[j-1];
        end
        key_mirror[slot]   = addr;
        iface_mirror[slot] = iface;
        pos_mirror[slot]   = fpos;
        held++;
      end
    end else if (kind == KIND_LOOKUP) begin
      r.status = ST_NOT_FOUND;
      for (int i = 0; i < held; i++) begin
        if (key_mirror[i] == addr && iface_mirror[i] == iface) begin
          r.status    = ST_OK;
          r.found_pos = pos_mirror[i];
          break;
        end
      end
    end else if (kind == KIND_CLEAR) begin
      held = 0;
    end
    r.entry_count = held[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      held = 0;
      reply_queue.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall)
        reply_queue.push_back(apply_request(in_kind, in_ip_addr, in_iface_id, in_file_pos));
      if (out_valid && !out_stall) begin
        if (reply_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected reply: status %0d pos %h count %0d",
                     out_status, out_found_pos, out_entry_count);
        end else begin
          want = reply_queue.pop_front();
          if (want.status !== out_status || want.found_pos !== out_found_pos ||
              want.entry_count !== out_entry_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("reply mismatch: exp status %0d pos %h count %0d, got %0d %h %0d",
                       want.status, want.found_pos, want.entry_count,
                       out_status, out_found_pos, out_entry_count);
          end
        end
      end
    end
    pending_count = reply_queue.size();
  end
endmodule

[test/tb_sorted_ip_record_table.sv]
// Testbench top for the sorted IP record table: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_sorted_ip_record_table;
  import sit_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_INSERT;
  logic [31:0] in_ip_addr = '0;
  logic [7:0]  in_iface_id = '0;
  logic [31:0] in_file_pos = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_found_pos;
  logic [8:0]  out_entry_count;
  int          fail_count;
  int          pending_count;

  // Idle percentages per side, changed by the stimulus process between phases.
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 74;
  bit          hold_off = 1'b0;   // long receiver stall for the pressure test

  // Addresses already inserted, so lookups mostly hit and duplicates pile up.
  logic [31:0] known_addr [$];
  logic [7:0]  known_iface [$];

  always #4 clk = ~clk;

  sorted_ip_record_table dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_ip_addr, .in_iface_id,
    .in_file_pos, .out_valid, .out_stall, .out_status, .out_found_pos, .out_entry_count
  );

  sit_result_checker checker_inst (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_ip_addr, .in_iface_id,
    .in_file_pos, .out_valid, .out_stall, .out_status, .out_found_pos, .out_entry_count,
    .fail_count, .pending_count
  );

  // Receiver: random stalls, or a solid stall while a hold-off is asked for.
  always @(posedge clk) begin
    if (hold_off)
      out_stall <= 1'b1;
    else
      out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offers one request and holds it until the block takes it. Random idle gaps
  // go in front, so valid is never dropped and raised in the same step.
  task automatic send_request(logic [1:0] kind, logic [31:0] addr, logic [7:0] iface,
                              logic [31:0] fpos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_ip_addr  <= addr;
    in_iface_id <= iface;
    in_file_pos <= fpos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == KIND_INSERT && known_addr.size() < 512) begin
      known_addr.push_back(addr);
      known_iface.push_back(iface);
    end
    if (kind == KIND_CLEAR) begin
      known_addr.delete();
      known_iface.delete();
    end
  endtask

  // Address drawn from a narrow cluster, the extremes or anywhere.
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return 32'hFFFF_FFF0 | $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(99);
    if (sel < 55) begin
      send_request(KIND_INSERT, pick_addr(),
                   $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3)),
                   $urandom);
    end else if (sel < 90 && known_addr.size() > 0) begin
      k = $urandom_range(known_addr.size() - 1);
      send_request(KIND_LOOKUP, known_addr[k],
                   $urandom_range(4) == 0 ? 8'($urandom) : known_iface[k], $urandom);
    end else if (sel < 96) begin
      send_request(KIND_LOOKUP, pick_addr(), 8'($urandom), $urandom);
    end else if (sel < 98) begin
      send_request(KIND_CLEAR, $urandom, 8'($urandom), $urandom);
    end else begin
      send_request(2'd3, $urandom, 8'($urandom), $urandom);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table lookup, extremes, duplicates in arrival order,
    // unused kind, clear, a lookup after clear.
    send_request(KIND_LOOKUP, 32'h0, 8'h0, 32'h0);
    send_request(KIND_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 32'h0, 8'h0, 32'h0);
    send_request(KIND_INSERT, 32'h8000_0000, 8'h5A, 32'h1111_1111);
    send_request(KIND_INSERT, 32'h8000_0000, 8'h5A, 32'h2222_2222);
    send_request(KIND_INSERT, 32'h8000_0000, 8'hA5, 32'h3333_3333);
    send_request(KIND_LOOKUP, 32'h8000_0000, 8'h5A, 32'h0);
    send_request(KIND_LOOKUP, 32'h8000_0000, 8'hA5, 32'h0);
    send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 32'h0);
    send_request(KIND_LOOKUP, 32'h0, 8'h0, 32'h0);
    send_request(KIND_LOOKUP, 32'h8000_0000, 8'h00, 32'h0);
    send_request(KIND_LOOKUP, 32'h1234_5678, 8'h5A, 32'h0);
    send_request(2'd3, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_request(KIND_CLEAR, 32'h0, 8'h0, 32'h0);
    send_request(KIND_LOOKUP, 32'h8000_0000, 8'h5A, 32'h0);

    // Fill the table past capacity so full refusals show up, then find, clear.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < CAPACITY_DEF + 3; i++)
      send_request(KIND_INSERT, $urandom_range(40), 8'($urandom_range(3)), $urandom);
    send_request(KIND_LOOKUP, 32'd7, 8'd1, 32'h0);
    send_request(KIND_CLEAR, 32'h0, 8'h0, 32'h0);
    drain();

    // Random phases: receiver idles, then sender idles, then neither.
    send_idle_pct = 30;
    recv_idle_pct = 74;
    for (int i = 0; i < 300; i++) random_request();
    send_idle_pct = 74;
    recv_idle_pct = 30;
    for (int i = 0; i < 300; i++) random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 150; i++) random_request();

    // Pressure: the receiver holds off while requests keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) random_request();
    join
    for (int i = 0; i < 200; i++) random_request();
    drain();

    // A full table's worth of inserts is slow, so settle a little longer.
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Worst case: ~1250 requests, many of them inserts into a nearly full table,
  // with stalls; the timeout allows well beyond their run time.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
